// File: rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared constants and codes for the message ring FIFO.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int MAX_READ_DEF    = 64;

    localparam int CAP_W  = 13;
    localparam int READ_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_DATA     = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_REJECTED = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

endpackage

// File: rtl/message_ring_fifo.sv
// ----------------------------------------------------------------------------
// message_ring_fifo
// Byte ring buffer holding zero-terminated messages in one synchronous RAM.
// ----------------------------------------------------------------------------
// A request is accepted when start is high and busy is low. A push request
// carries one message byte and does not raise busy, so pushes stream at one
// byte per clock while no pop holds busy. The byte marked by byte_last gives
// one status result in the next cycle: accepted or rejected. A pop request on
// an empty queue gives one empty status result in the next cycle. A pop on a
// filled queue raises busy while the head message is read from the RAM one
// byte per cycle; data results pass through the RAM read register and the
// output registers, then follow one per cycle up to the read limit. Busy
// stays high until the whole head message is scanned and discarded, even
// when the read limit cuts it short. The single RAM read port sets the scan
// rate. Results are held on the result ports for exactly one cycle, marked by
// result_valid; the receiver cannot stall them. Reset empties the queue
// and restores the capacity limit to its full value; the RAM contents are
// not cleared, since only committed bytes are ever read.
// ----------------------------------------------------------------------------
module message_ring_fifo
    import mrf_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_READ    = MAX_READ_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              opcode,
    input  logic [7:0]        data_byte,
    input  logic              byte_last,
    input  logic [READ_W-1:0] read_limit,
    input  logic              cfg_write,
    input  logic [CAP_W-1:0]  cfg_wdata,
    output logic              result_valid,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [1:0]        status
);

    localparam int PTR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 2;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(STORE_DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(STORE_DEPTH);
    localparam logic [READ_W-1:0] READ_MAX = READ_W'(MAX_READ);

    logic [7:0]        mem [STORE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic [PTR_W-1:0]  rd_addr;

    state_t            state_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  rptr_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  pending_reg;
    logic              overflow_reg;
    logic [CNT_W-1:0]  index_reg;
    logic [READ_W-1:0] limit_reg;

    logic              accept;
    logic              push_room;
    logic [SUM_W-1:0]  bound;
    logic [SUM_W-1:0]  total_next;
    logic [PTR_W-1:0]  wptr_inc;
    logic [PTR_W-1:0]  rptr_inc;
    logic [PTR_W-1:0]  head_inc;
    logic [PTR_W-1:0]  head_next;
    logic [SUM_W-1:0]  head_sum;
    logic [CNT_W-1:0]  index_inc;
    logic [READ_W-1:0] limit_next;
    logic              msg_end;
    logic              emit;
    logic              emit_final;
    logic              result_next;

    assign busy   = (state_reg == ST_POP);
    assign accept = start && !busy;

    assign bound      = (SUM_W'(capacity_reg) > DEPTH_S) ? DEPTH_S : SUM_W'(capacity_reg);
    assign total_next = SUM_W'(used_reg) + SUM_W'(pending_reg) + SUM_W'(2);
    assign push_room  = !overflow_reg && (total_next < bound);

    assign wptr_inc = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
    assign rptr_inc = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + PTR_W'(1);

    assign index_inc = index_reg + CNT_W'(1);
    assign head_sum  = SUM_W'(head_reg) + SUM_W'(index_inc);
    assign head_next = (head_sum >= DEPTH_S) ? PTR_W'(head_sum - DEPTH_S) : PTR_W'(head_sum);

    assign msg_end    = (rd_data_reg == 8'd0) || (index_inc == used_reg);
    assign emit       = SUM_W'(index_reg) < SUM_W'(limit_reg);
    assign emit_final = msg_end || (SUM_W'(index_inc) == SUM_W'(limit_reg));

    assign rd_addr = (state_reg == ST_POP) ? rptr_reg : head_reg;

    assign result_next = busy ? emit
                       : (accept && ((opcode == OP_POP) ? (used_reg == '0) : byte_last));

    always_comb
    begin
        limit_next = read_limit;
        if (read_limit == '0)
        begin
            limit_next = READ_W'(1);
        end
        else if (read_limit > READ_MAX)
        begin
            limit_next = READ_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (accept && (opcode == OP_PUSH) && push_room)
        begin
            mem[wptr_reg] <= byte_last ? 8'd0 : data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            used_reg     <= '0;
            pending_reg  <= '0;
            overflow_reg <= 1'b0;
            index_reg    <= '0;
            limit_reg    <= READ_W'(1);
            result_valid <= 1'b0;
            out_byte     <= 8'd0;
            out_last     <= 1'b0;
            status       <= STATUS_DATA;
        end
        else
        begin
            result_valid <= result_next;
            if (cfg_write)
            begin
                capacity_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (opcode == OP_PUSH))
                    begin
                        if (byte_last)
                        begin
                            out_byte <= 8'd0;
                            out_last <= 1'b1;
                            if (push_room)
                            begin
                                tail_reg <= wptr_inc;
                                wptr_reg <= wptr_inc;
                                used_reg <= used_reg + pending_reg + CNT_W'(1);
                                status   <= STATUS_ACCEPTED;
                            end
                            else
                            begin
                                wptr_reg <= tail_reg;
                                status   <= STATUS_REJECTED;
                            end
                            pending_reg  <= '0;
                            overflow_reg <= 1'b0;
                        end
                        else if (push_room)
                        begin
                            pending_reg <= pending_reg + CNT_W'(1);
                            wptr_reg    <= wptr_inc;
                        end
                        else
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                    else if (accept && (opcode == OP_POP))
                    begin
                        if (used_reg == '0)
                        begin
                            out_byte <= 8'd0;
                            out_last <= 1'b1;
                            status   <= STATUS_EMPTY;
                        end
                        else
                        begin
                            state_reg <= ST_POP;
                            rptr_reg  <= head_inc;
                            index_reg <= '0;
                            limit_reg <= limit_next;
                        end
                    end
                end
                ST_POP:
                begin
                    rptr_reg  <= rptr_inc;
                    index_reg <= index_inc;
                    if (emit)
                    begin
                        out_byte <= emit_final ? 8'd0 : rd_data_reg;
                        out_last <= emit_final;
                        status   <= STATUS_DATA;
                    end
                    if (msg_end)
                    begin
                        head_reg  <= head_next;
                        used_reg  <= used_reg - index_inc;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_used_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(used_reg) + SUM_W'(pending_reg)) < DEPTH_S)
        else $error("Queue and pending bytes exceed the store.");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_POP) && (used_reg == '0)
        |=> result_valid && out_last && (status == STATUS_EMPTY))
        else $error("Pop on empty queue gave no empty status.");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (opcode == OP_POP) && (used_reg != '0) |=> busy)
        else $error("Pop on filled queue did not start streaming.");

    a_data_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == STATUS_DATA) |-> $past(state_reg == ST_POP))
        else $error("Data result outside a pop.");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the message ring FIFO.
// ----------------------------------------------------------------------------
// Push and pop requests are sent through the start/busy handshake with random
// idle gaps. A behavioral copy of the queue predicts every status and popped
// byte. A checker compares each strobed output against the oldest prediction.
// The run covers pops on an empty queue and terminator forcing. It also covers
// interior zero bytes, read-limit truncation and pops during a partial push.
// Several capacity settings are used, including the degenerate ones.
// ----------------------------------------------------------------------------
module tb;
    import mrf_pkg::*;

    localparam int RING_W = $clog2(STORE_DEPTH_DEF);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } fifo_output_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              opcode = OP_PUSH;
    logic [7:0]        data_byte = 8'h00;
    logic              byte_last = 1'b0;
    logic [READ_W-1:0] read_limit = '0;
    logic              cfg_write = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              result_valid;
    logic [7:0]        out_byte;
    logic              out_last;
    logic [1:0]        status;

    fifo_output_t      due_outputs[$];
    logic [7:0]        ring_bytes[0:STORE_DEPTH_DEF-1];
    int unsigned       head_idx = 0;
    int unsigned       tail_idx = 0;
    int unsigned       queued_bytes = 0;
    int unsigned       open_bytes = 0;
    bit                open_overflow = 1'b0;
    logic [CAP_W-1:0]  cap_limit = CAP_RESET;

    int unsigned       requests_sent = 0;
    int unsigned       mismatch_count = 0;
    bit                burst_mode = 1'b0;

    message_ring_fifo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .byte_last    (byte_last),
        .read_limit   (read_limit),
        .cfg_write    (cfg_write),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void ring_apply_request(input logic op, input logic [7:0] data,
                                               input logic last,
                                               input logic [READ_W-1:0] rlim);
        int unsigned bound;
        int unsigned total;
        int unsigned scan_len;
        int unsigned lim;
        int unsigned take;
        bit          room;
        fifo_output_t item;
        bound = (cap_limit > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : cap_limit;
        if (op == OP_PUSH)
        begin
            total = queued_bytes + open_bytes + 1;
            room = !open_overflow && (total + 1 < bound);
            if (room)
            begin
                ring_bytes[RING_W'((tail_idx + open_bytes) % STORE_DEPTH_DEF)] =
                    last ? 8'h00 : data;
                open_bytes++;
            end
            else
            begin
                open_overflow = 1'b1;
            end
            if (last)
            begin
                if (room)
                begin
                    tail_idx = (tail_idx + open_bytes) % STORE_DEPTH_DEF;
                    queued_bytes += open_bytes;
                    item = '{8'h00, 1'b1, STATUS_ACCEPTED};
                end
                else
                begin
                    item = '{8'h00, 1'b1, STATUS_REJECTED};
                end
                due_outputs.push_back(item);
                open_bytes = 0;
                open_overflow = 1'b0;
            end
        end
        else if (queued_bytes == 0)
        begin
            item = '{8'h00, 1'b1, STATUS_EMPTY};
            due_outputs.push_back(item);
        end
        else
        begin
            scan_len = 1;
            while (scan_len < queued_bytes &&
                   ring_bytes[RING_W'((head_idx + scan_len - 1) % STORE_DEPTH_DEF)] != 8'h00)
                scan_len++;
            lim = (rlim == 0) ? 1 : ((rlim > MAX_READ_DEF) ? MAX_READ_DEF : rlim);
            take = (scan_len < lim) ? scan_len : lim;
            for (int unsigned i = 0; i < take; i++)
            begin
                if (i + 1 == take)
                    item = '{8'h00, 1'b1, STATUS_DATA};
                else
                    item = '{ring_bytes[RING_W'((head_idx + i) % STORE_DEPTH_DEF)], 1'b0,
                             STATUS_DATA};
                due_outputs.push_back(item);
            end
            head_idx = (head_idx + scan_len) % STORE_DEPTH_DEF;
            queued_bytes -= scan_len;
        end
    endfunction

    function automatic void report_mismatch(input fifo_output_t want, input fifo_output_t seen,
                                            input bit unexpected);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            if (unexpected)
                $display("unexpected output: byte %02h last %0b status %0d",
                         seen.data, seen.last, seen.status);
            else
                $display("mismatch: expected byte %02h last %0b status %0d, got byte %02h last %0b status %0d",
                         want.data, want.last, want.status, seen.data, seen.last, seen.status);
        end
    endfunction

    always @(posedge clk)
    begin : output_check
        fifo_output_t seen;
        fifo_output_t want;
        if (result_valid === 1'b1)
        begin
            seen = {out_byte, out_last, status};
            if (due_outputs.size() == 0)
            begin
                want = '0;
                report_mismatch(want, seen, 1'b1);
            end
            else
            begin
                want = due_outputs.pop_front();
                if (seen !== want)
                    report_mismatch(want, seen, 1'b0);
            end
        end
    end

    function automatic logic [7:0] random_payload_byte();
        return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_request(input logic op, input logic [7:0] data, input logic last,
                                input logic [READ_W-1:0] rlim);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        data_byte  <= data;
        byte_last  <= last;
        read_limit <= rlim;
        do @(posedge clk); while (busy !== 1'b0);
        ring_apply_request(op, data, last, rlim);
        requests_sent++;
    endtask

    task automatic send_message(input int unsigned length);
        for (int unsigned i = 1; i <= length; i++)
            send_request(OP_PUSH, random_payload_byte(), i == length,
                         READ_W'($urandom_range(0, 127)));
    endtask

    task automatic send_random_pop();
        send_request(OP_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     READ_W'($urandom_range(0, 127)));
    endtask

    task automatic settle_queue();
        start <= 1'b0;
        while (due_outputs.size() != 0 || busy !== 1'b0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cap_limit = value;
        cfg_write <= 1'b0;
    endtask

    task automatic test_empty_pop();
        send_request(OP_POP, 8'h00, 1'b0, 7'd0);
    endtask

    task automatic test_terminator_and_interior_zero();
        send_request(OP_PUSH, 8'hFF, 1'b0, 7'd127);
        send_request(OP_PUSH, 8'h00, 1'b0, 7'd0);
        send_request(OP_PUSH, 8'h01, 1'b0, 7'd64);
        send_request(OP_PUSH, 8'hAA, 1'b1, 7'd1);
        send_request(OP_POP, 8'hFF, 1'b1, 7'd127);
        send_request(OP_POP, 8'h00, 1'b0, 7'd1);
        send_request(OP_POP, 8'h5A, 1'b0, 7'd64);
    endtask

    task automatic test_pop_during_push();
        send_request(OP_PUSH, 8'h55, 1'b0, 7'd3);
        send_request(OP_POP, 8'h00, 1'b0, 7'd5);
        send_request(OP_PUSH, 8'h80, 1'b1, 7'd3);
        send_request(OP_POP, 8'h00, 1'b0, 7'd5);
    endtask

    task automatic test_capacity_extremes();
        settle_queue();
        write_capacity('0);
        send_request(OP_PUSH, 8'hC3, 1'b1, 7'd0);
        settle_queue();
        write_capacity(13'd1);
        send_request(OP_PUSH, 8'h3C, 1'b1, 7'd0);
        settle_queue();
        write_capacity(13'd2);
        send_request(OP_PUSH, 8'h0F, 1'b1, 7'd0);
        settle_queue();
        write_capacity(13'd3);
        send_request(OP_PUSH, 8'hF0, 1'b1, 7'd0);
        send_request(OP_PUSH, 8'h99, 1'b1, 7'd0);
        send_request(OP_POP, 8'h00, 1'b0, 7'd2);
        settle_queue();
        write_capacity(13'd6);
        for (int unsigned i = 0; i < 5; i++)
            send_request(OP_PUSH, 8'(8'h11 * (i + 1)), 1'b0, 7'd0);
        send_request(OP_PUSH, 8'h77, 1'b1, 7'd0);
        settle_queue();
    endtask

    task automatic test_random_traffic();
        logic [CAP_W-1:0] phase_caps[5] = '{13'd8191, 13'd24, 13'd4096, 13'd3, 13'd300};
        int unsigned      phase_end;
        int unsigned      pick;
        foreach (phase_caps[p])
        begin
            settle_queue();
            write_capacity(phase_caps[p]);
            phase_end = requests_sent + 60;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 15) == 0)
                    burst_mode = !burst_mode;
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    send_message($urandom_range(1, 10));
                end
                else if (pick < 52)
                begin
                    send_message($urandom_range(65, 80));
                end
                else if (pick < 60)
                begin
                    send_request(OP_PUSH, random_payload_byte(), 1'b0,
                                 READ_W'($urandom_range(0, 127)));
                    send_random_pop();
                    send_message($urandom_range(1, 4));
                end
                else
                begin
                    send_random_pop();
                end
            end
            burst_mode = 1'b0;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_pop();
        test_terminator_and_interior_zero();
        test_pop_during_push();
        test_capacity_extremes();
        test_random_traffic();
        start <= 1'b0;
        while (due_outputs.size() != 0 || busy !== 1'b0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && due_outputs.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
